FILE: hw/rtl/fpr_pkg.sv
// shared constants and control types for the fifo page replacement block
package fpr_pkg;

    // fixed field widths
    localparam int PAGE_W     = 4;
    localparam int FRAME_W    = 3;
    localparam int EVPAGE_W   = 4;
    localparam int COUNT_W    = 16;
    localparam int CFG_W      = 4;
    localparam int STAMP_W    = 32;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;
    localparam int PAGE_SPAN  = 2 ** PAGE_W;

    // result packing: fault, frame, evicted_valid, evicted_page, fault_count
    localparam int M_USED_W   = 1 + FRAME_W + 1 + EVPAGE_W + COUNT_W;
    localparam int M_PAD_W    = M_TDATA_W - M_USED_W;
    localparam int S_PAD_W    = S_TDATA_W - PAGE_W;

    // parameter defaults
    localparam int NUM_PAGES_DEF  = 16;
    localparam int NUM_FRAMES_DEF = 8;

    localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(8);
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

    // oldest-frame search control
    typedef struct packed {
        logic sample;
        logic first;
    } scan_cmd_t;

    // page map update control
    typedef struct packed {
        logic set;
        logic clr;
    } pmap_cmd_t;

endpackage

FILE: hw/rtl/fpr_oldest_unit.sv
// shared stamp comparator that tracks the oldest filled frame during a scan
module fpr_oldest_unit import fpr_pkg::*; #(
    parameter int FIW = 3,
    parameter int PIW = 4
) (
    input  logic                 aclk,
    input  scan_cmd_t            cmd,
    input  logic [FIW-1:0]       idx,
    input  logic [STAMP_W-1:0]   stamp,
    input  logic [PIW-1:0]       page,
    output logic [FIW-1:0]       oldest_idx_next,
    output logic [PIW-1:0]       oldest_page_next
);

    logic [FIW-1:0]     oldest_idx_reg;
    logic [STAMP_W-1:0] oldest_stamp_reg;
    logic [STAMP_W-1:0] oldest_stamp_next;
    logic [PIW-1:0]     oldest_page_reg;
    logic               take;

    // strict less-than keeps the lowest frame among equal stamps
    assign take = cmd.sample && (cmd.first || (stamp < oldest_stamp_reg));

    always_comb begin
        oldest_idx_next   = oldest_idx_reg;
        oldest_stamp_next = oldest_stamp_reg;
        oldest_page_next  = oldest_page_reg;
        if (take) begin
            oldest_idx_next   = idx;
            oldest_stamp_next = stamp;
            oldest_page_next  = page;
        end
    end

    always_ff @(posedge aclk) begin
        oldest_idx_reg   <= oldest_idx_next;
        oldest_stamp_reg <= oldest_stamp_next;
        oldest_page_reg  <= oldest_page_next;
    end

endmodule

FILE: hw/rtl/fpr_page_map.sv
// page map: resident bits in flops and a frame-number memory per page
module fpr_page_map import fpr_pkg::*; #(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int PIW       = 4,
    parameter int FIW       = 3
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [PIW-1:0] rd_page,
    output logic           rd_resident,
    output logic [FIW-1:0] rd_frame,
    input  pmap_cmd_t      cmd,
    input  logic [PIW-1:0] set_page,
    input  logic [FIW-1:0] set_frame,
    input  logic [PIW-1:0] clr_page
);

    logic [NUM_PAGES-1:0] resident_reg;
    logic [FIW-1:0]       frame_mem [NUM_PAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resident_reg <= '0;
            rd_resident  <= 1'b0;
        end else begin
            rd_resident <= resident_reg[rd_page];
            if (cmd.clr) begin
                resident_reg[clr_page] <= 1'b0;
            end
            if (cmd.set) begin
                resident_reg[set_page] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_frame <= frame_mem[rd_page];
        if (cmd.set) begin
            frame_mem[set_page] <= set_frame;
        end
    end

endmodule

FILE: hw/rtl/fifo_page_replacement_top.sv
// top level of the fifo page replacement block: sequencer, frame memories, result register
//
// Each input transfer carries one page reference; each reference yields exactly one
// result transfer with the hit/fault flag, the frame now holding the page, the evicted
// page if any and the saturating fault total. One reference is handled at a time and
// s_tready is low while it is in flight. A hit passes through the page map read, the
// decision and the result load. A miss walks the frames in use one per cycle through a
// single shared stamp comparator, stopping at the first empty frame, then writes the
// chosen frame and loads the result. The result register lets the next reference be
// taken while a finished result still waits on m_tready. frames_in_use is written over
// cfg_wr_en / cfg_wr_data; the user must write it only while no reference is in flight,
// and the block itself does not enforce this. 0 acts as 1 and values above NUM_FRAMES
// act as NUM_FRAMES. No clearing pass is needed after reset.
module fifo_page_replacement_top import fpr_pkg::*; #(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // frames_in_use register
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    // page reference in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [3:0] page, rest zero
    // result out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [0] fault, [3:1] frame, [4] evicted_valid,
                                            // [8:5] evicted_page, [24:9] fault_count
);

    localparam int PIW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int FIW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t                state_reg;
    logic [PIW-1:0]        page_reg;
    logic [STAMP_W-1:0]    time_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [CFG_W-1:0]      cfg_reg;
    logic [FIW-1:0]        last_reg;
    logic [FIW-1:0]        cmp_idx_reg;
    logic [FIW-1:0]        chosen_reg;
    logic                  res_fault_reg;
    logic                  res_ev_valid_reg;
    logic [PIW-1:0]        res_ev_page_reg;
    logic [NUM_FRAMES-1:0] filled_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    // page number folded into range, worked out at elaboration
    logic [PIW-1:0] page_fold [PAGE_SPAN];
    for (genvar g = 0; g < PAGE_SPAN; g++) begin : g_fold
        assign page_fold[g] = PIW'(g % NUM_PAGES);
    end

    logic [PIW-1:0] s_page_fold;
    assign s_page_fold = page_fold[s_tdata[PAGE_W-1:0]];

    // frame count clamp: 0 acts as 1, above NUM_FRAMES acts as NUM_FRAMES
    logic [7:0]     cfg_ext;
    logic [7:0]     lim_ext;
    logic [FIW-1:0] last_idx;
    always_comb begin
        cfg_ext = 8'(cfg_reg);
        if (cfg_ext == 8'd0) begin
            lim_ext = 8'd1;
        end else if (cfg_ext > 8'(NUM_FRAMES)) begin
            lim_ext = 8'(NUM_FRAMES);
        end else begin
            lim_ext = cfg_ext;
        end
        last_idx = FIW'(lim_ext - 8'd1);
    end

    // page map
    logic           pmap_resident;
    logic [FIW-1:0] pmap_frame;
    logic [PIW-1:0] pmap_rd_page;
    pmap_cmd_t      pmap_cmd;

    assign pmap_rd_page = (state_reg == ST_IDLE) ? s_page_fold : page_reg;
    assign pmap_cmd.set = (state_reg == ST_WRITE);
    assign pmap_cmd.clr = (state_reg == ST_WRITE) && res_ev_valid_reg;

    fpr_page_map #(
        .NUM_PAGES (NUM_PAGES),
        .PIW       (PIW),
        .FIW       (FIW)
    ) u_page_map (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rd_page     (pmap_rd_page),
        .rd_resident (pmap_resident),
        .rd_frame    (pmap_frame),
        .cmd         (pmap_cmd),
        .set_page    (page_reg),
        .set_frame   (chosen_reg),
        .clr_page    (res_ev_page_reg)
    );

    // frame memories: page held and load stamp, one registered read port for the scan
    logic [PIW-1:0]     fpage_mem [NUM_FRAMES];
    logic [STAMP_W-1:0] stamp_mem [NUM_FRAMES];
    logic [PIW-1:0]     fpage_rd_reg;
    logic [STAMP_W-1:0] stamp_rd_reg;
    logic [FIW-1:0]     fmem_rd_addr;
    logic               scan_last;
    logic               filled_now;

    assign scan_last  = (cmp_idx_reg == last_reg);
    assign filled_now = filled_reg[cmp_idx_reg];

    // prefetch the next frame while the current one is compared
    always_comb begin
        if (state_reg == ST_SCAN && !scan_last) begin
            fmem_rd_addr = cmp_idx_reg + FIW'(1);
        end else if (state_reg == ST_SCAN) begin
            fmem_rd_addr = cmp_idx_reg;
        end else begin
            fmem_rd_addr = '0;
        end
    end

    always_ff @(posedge aclk) begin
        fpage_rd_reg <= fpage_mem[fmem_rd_addr];
        stamp_rd_reg <= stamp_mem[fmem_rd_addr];
        if (state_reg == ST_WRITE) begin
            fpage_mem[chosen_reg] <= page_reg;
            stamp_mem[chosen_reg] <= time_reg;
        end
    end

    // shared comparator for the oldest stamp
    scan_cmd_t      scan_cmd;
    logic [FIW-1:0] oldest_idx_next;
    logic [PIW-1:0] oldest_page_next;

    assign scan_cmd.sample = (state_reg == ST_SCAN) && filled_now;
    assign scan_cmd.first  = (cmp_idx_reg == '0);

    fpr_oldest_unit #(
        .FIW (FIW),
        .PIW (PIW)
    ) u_oldest (
        .aclk             (aclk),
        .cmd              (scan_cmd),
        .idx              (cmp_idx_reg),
        .stamp            (stamp_rd_reg),
        .page             (fpage_rd_reg),
        .oldest_idx_next  (oldest_idx_next),
        .oldest_page_next (oldest_page_next)
    );

    // result word
    logic [M_TDATA_W-1:0] result_word;
    assign result_word = {
        {M_PAD_W{1'b0}},
        count_reg,
        EVPAGE_W'(res_ev_page_reg),
        res_ev_valid_reg,
        FRAME_W'(chosen_reg),
        res_fault_reg
    };

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            time_reg     <= '0;
            count_reg    <= '0;
            cfg_reg      <= FRAMES_RESET;
            filled_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            // in ST_DONE a new result may replace the one leaving, handled there
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        page_reg  <= s_page_fold;
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    res_ev_valid_reg <= 1'b0;
                    res_ev_page_reg  <= '0;
                    if (pmap_resident) begin
                        // hit: nothing changes
                        res_fault_reg <= 1'b0;
                        chosen_reg    <= pmap_frame;
                        state_reg     <= ST_DONE;
                    end else begin
                        res_fault_reg <= 1'b1;
                        if (count_reg != COUNT_MAX) begin
                            count_reg <= count_reg + COUNT_W'(1);
                        end
                        last_reg    <= last_idx;
                        cmp_idx_reg <= '0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (!filled_now) begin
                        // first empty frame wins
                        chosen_reg <= cmp_idx_reg;
                        state_reg  <= ST_WRITE;
                    end else if (scan_last) begin
                        // all full: replace the oldest
                        chosen_reg       <= oldest_idx_next;
                        res_ev_valid_reg <= 1'b1;
                        res_ev_page_reg  <= oldest_page_next;
                        state_reg        <= ST_WRITE;
                    end else begin
                        cmp_idx_reg <= cmp_idx_reg + FIW'(1);
                    end
                end
                ST_WRITE: begin
                    filled_reg[chosen_reg] <= 1'b1;
                    state_reg              <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= result_word;
                        time_reg     <= time_reg + STAMP_W'(1);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
